// ===== hw/rtl/dvcm_pkg.sv =====
// package for the distinct value class mapper
// holds table sizing constants, the controller state type and the cell control struct
// no dependencies
package dvcm_pkg;

    localparam int MAX_CLASSES = 32;
    localparam int COUNT_BITS  = 20;

    localparam int WORD_W      = 64;
    localparam int INDEX_W     = 5;
    localparam int COUNT_OUT_W = 20;

    localparam int USED_W  = $clog2(MAX_CLASSES + 1);
    localparam int SLOT_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int IDXE_W  = (USED_W > INDEX_W) ? USED_W : INDEX_W;
    localparam int SLOTE_W = (SLOT_W > INDEX_W) ? SLOT_W : INDEX_W;
    localparam int CNTE_W  = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic shift;
        logic in_use;
        logic claim;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/dvcm_if.sv =====
// stream interfaces of the distinct value class mapper
// input samples and output results, valid/ready handshake
// no dependencies
interface dvcm_sample_if;
    logic        valid;
    logic        ready;
    logic [63:0] sample_value;
    logic        end_of_set;

    modport source (output valid, output sample_value, output end_of_set, input ready);
    modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface dvcm_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [4:0]  class_index;
    logic [63:0] entry_value;
    logic [19:0] entry_count;
    logic        table_overflow;
    logic        final_result;

    modport source (output valid, output result_kind, output class_index,
                    output entry_value, output entry_count, output table_overflow,
                    output final_result, input ready);
    modport sink   (input valid, input result_kind, input class_index,
                    input entry_value, input entry_count, input table_overflow,
                    input final_result, output ready);
endinterface

// ===== hw/rtl/dvcm_cell.sv =====
// one table cell: stores a distinct word and its saturating count
// compares against the broadcast word and shifts toward its lower neighbor on dump
// depends on dvcm_pkg
module dvcm_cell (
    input  logic                              clk,
    input  dvcm_pkg::cell_ctrl_t              ctrl,
    input  logic [dvcm_pkg::WORD_W-1:0]       word,
    input  logic [dvcm_pkg::WORD_W-1:0]       shift_value,
    input  logic [dvcm_pkg::COUNT_BITS-1:0]   shift_count,
    output logic [dvcm_pkg::WORD_W-1:0]       value,
    output logic [dvcm_pkg::COUNT_BITS-1:0]   count,
    output logic                              match
);
    import dvcm_pkg::*;

    logic [WORD_W-1:0]     value_reg;
    logic [COUNT_BITS-1:0] count_reg;

    assign match = ctrl.in_use && (value_reg == word);
    assign value = value_reg;
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= shift_value;
            count_reg <= shift_count;
        end
        else if (ctrl.exec && ctrl.claim)
        begin
            value_reg <= word;
            count_reg <= COUNT_BITS'(1);
        end
        else if (ctrl.exec && match && (count_reg != COUNT_MAX))
        begin
            count_reg <= count_reg + COUNT_BITS'(1);
        end
    end

endmodule

// ===== hw/rtl/distinct_value_class_mapper.sv =====
// top level of the distinct value class mapper
// controller, output register and the row of dvcm_cell table cells
// depends on dvcm_pkg, dvcm_if (dvcm_sample_if, dvcm_result_if) and dvcm_cell
//
// The block keeps a table of up to MAX_CLASSES distinct 64-bit words in a row of
// cells, each with a saturating occurrence count. Every sample transfer gives one
// index result carrying the word's slot; a word that is new and finds the table
// full gets slot 0 with table_overflow set and is not stored. A sample marked
// end_of_set is followed by a dump of every stored entry in slot order, the last
// one flagged final_result, after which the table is empty again. A sample word
// is registered on transfer, then all cells compare in parallel and the hit cell
// (or the next free one) is updated; samples are accepted only in the idle state,
// so not during the execute or dump step. For a sample with end_of_set the dump
// shifts the whole row one cell per result toward cell 0, which feeds the output
// register. Back-pressure on results stalls the execute and dump steps; the output
// register lets a result wait while the next sample is taken.
// Equality is plain bit equality, so floating-point words must be canonical.
module distinct_value_class_mapper (
    input  logic                 clk,
    input  logic                 rst_n,
    dvcm_sample_if.sink          samples,
    dvcm_result_if.source        results
);
    import dvcm_pkg::*;

    // controller state
    ctrl_state_t          state_reg, state_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [USED_W-1:0]    dump_idx_reg, dump_idx_next;

    // captured sample
    logic [WORD_W-1:0]    word_reg;
    logic                 last_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [WORD_W-1:0]    value_reg, value_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 final_reg, final_next;

    // cell row
    cell_ctrl_t           cell_ctrl [MAX_CLASSES];
    logic [WORD_W-1:0]    cell_value [MAX_CLASSES];
    logic [COUNT_BITS-1:0] cell_count [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] match_vec;

    logic                 out_load;
    logic                 sample_xfer;
    logic                 any_hit;
    logic                 room;
    logic                 do_exec;
    logic                 do_shift;
    logic [SLOT_W-1:0]    hit_slot;
    logic [SLOT_W-1:0]    result_slot;
    logic [SLOTE_W-1:0]   slot_ext;
    logic [IDXE_W-1:0]    dump_idx_ext;
    logic [CNTE_W-1:0]    head_count_ext;
    logic                 dump_last;

    assign out_load    = !out_valid_reg || results.ready;
    assign sample_xfer = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    // values in the table are distinct, so at most one cell matches
    assign any_hit = |match_vec;
    assign room    = (used_reg < USED_W'(MAX_CLASSES));

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            if (match_vec[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    // slot reported in the index result: hit slot, next free slot, or 0 on overflow
    always_comb
    begin
        if (any_hit)
        begin
            result_slot = hit_slot;
        end
        else if (room)
        begin
            result_slot = used_reg[SLOT_W-1:0];
        end
        else
        begin
            result_slot = '0;
        end
    end

    assign slot_ext       = SLOTE_W'(result_slot);
    assign dump_idx_ext   = IDXE_W'(dump_idx_reg);
    assign head_count_ext = CNTE_W'(cell_count[0]);
    assign dump_last      = (dump_idx_reg == (used_reg - USED_W'(1)));

    assign do_exec  = (state_reg == ST_EXEC) && out_load;
    assign do_shift = (state_reg == ST_DUMP) && out_load;

    // per-cell control, positions are constants
    always_comb
    begin
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            cell_ctrl[i].exec   = do_exec;
            cell_ctrl[i].shift  = do_shift;
            cell_ctrl[i].in_use = (USED_W'(i) < used_reg);
            cell_ctrl[i].claim  = (used_reg == USED_W'(i)) && !any_hit && room;
        end
    end

    // the row: each cell takes its upper neighbor's contents during a dump
    for (genvar g = 0; g < MAX_CLASSES; g++)
    begin : g_cell
        if (g == MAX_CLASSES - 1)
        begin : g_tail
            dvcm_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[g]),
                .word        (word_reg),
                .shift_value (cell_value[g]),
                .shift_count (cell_count[g]),
                .value       (cell_value[g]),
                .count       (cell_count[g]),
                .match       (match_vec[g])
            );
        end
        else
        begin : g_body
            dvcm_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[g]),
                .word        (word_reg),
                .shift_value (cell_value[g+1]),
                .shift_count (cell_count[g+1]),
                .value       (cell_value[g]),
                .count       (cell_count[g]),
                .match       (match_vec[g])
            );
        end
    end

    // next state and output register load
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !results.ready;
        kind_next      = kind_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        final_next     = final_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b0;
                    index_next     = slot_ext[INDEX_W-1:0];
                    value_next     = '0;
                    count_next     = '0;
                    ovf_next       = !any_hit && !room;
                    final_next     = !last_reg;
                    if (!any_hit && room)
                    begin
                        used_next = used_reg + USED_W'(1);
                    end
                    state_next = last_reg ? ST_DUMP : ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    index_next     = dump_idx_ext[INDEX_W-1:0];
                    value_next     = cell_value[0];
                    count_next     = head_count_ext[COUNT_OUT_W-1:0];
                    ovf_next       = 1'b0;
                    final_next     = dump_last;
                    if (dump_last)
                    begin
                        dump_idx_next = '0;
                        used_next     = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + USED_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            word_reg <= samples.sample_value;
            last_reg <= samples.end_of_set;
        end
        kind_reg  <= kind_next;
        index_reg <= index_next;
        value_reg <= value_next;
        count_reg <= count_next;
        ovf_reg   <= ovf_next;
        final_reg <= final_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.result_kind    = kind_reg;
    assign results.class_index    = index_reg;
    assign results.entry_value    = value_reg;
    assign results.entry_count    = count_reg;
    assign results.table_overflow = ovf_reg;
    assign results.final_result   = final_reg;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(MAX_CLASSES))
        else $error("fill count beyond table size");

    // stored words are distinct, so the compare never hits twice
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(match_vec))
        else $error("more than one cell matched");

    // dump position stays inside the filled part of the table
    a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (dump_idx_reg < used_reg))
        else $error("dump position past fill count");

    // the table is never empty when a dump starts
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (do_exec && last_reg) |=> (used_reg != '0))
        else $error("dump started on empty table");

endmodule

// ===== tb/distinct_value_class_mapper_tb.sv =====
// self-checking testbench for distinct_value_class_mapper
// checks every result against a table model kept in the bench, with random stalls on both streams
// depends on dvcm_pkg, dvcm_if and the distinct_value_class_mapper rtl
module distinct_value_class_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvcm_pkg::*;

    // cycles with no transfer on either stream before the run is called hung
    localparam int HANG_LIMIT = 2000;
    // quiet cycles after the last expected result, covers a full dump with stalls
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } sample_t;

    typedef struct packed {
        logic                   kind;
        logic [INDEX_W-1:0]     cls;
        logic [WORD_W-1:0]      word;
        logic [COUNT_OUT_W-1:0] hits;
        logic                   ovf;
        logic                   fin;
    } class_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dvcm_sample_if samples ();
    dvcm_result_if results ();

    distinct_value_class_mapper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    always #6 clk = ~clk;

    // words waiting to be sent and results waiting to come back
    sample_t       pending_samples[$];
    class_result_t expected_results[$];

    // bench copy of the class table
    logic [WORD_W-1:0] class_words [MAX_CLASSES];
    logic [CNTE_W-1:0] class_hits  [MAX_CLASSES];
    int                classes_used = 0;

    int  mismatch_count = 0;
    int  idle_cycles    = 0;

    // update the table with one accepted word and queue the results it causes
    function automatic void classify_sample(input logic [WORD_W-1:0] word, input logic last);
        int            slot;
        bit            hit;
        bit            ovf;
        class_result_t r;
        slot = 0;
        hit  = 1'b0;
        ovf  = 1'b0;
        for (int i = 0; i < classes_used; i++)
        begin
            if (!hit && class_words[i] == word)
            begin
                slot = i;
                hit  = 1'b1;
            end
        end
        if (hit)
        begin
            // count stops at its ceiling
            if (class_hits[slot] != CNTE_W'(COUNT_MAX))
                class_hits[slot] = class_hits[slot] + CNTE_W'(1);
        end
        else if (classes_used < MAX_CLASSES)
        begin
            slot = classes_used;
            class_words[slot] = word;
            class_hits[slot]  = CNTE_W'(1);
            classes_used++;
        end
        else
        begin
            // table full: word is dropped and reported against slot 0
            ovf = 1'b1;
        end
        r.kind = 1'b0;
        r.cls  = slot[INDEX_W-1:0];
        r.word = '0;
        r.hits = '0;
        r.ovf  = ovf;
        r.fin  = !last;
        expected_results.push_back(r);
        if (last)
        begin
            // end of set: dump every entry in slot order, then empty the table
            for (int i = 0; i < classes_used; i++)
            begin
                r.kind = 1'b1;
                r.cls  = i[INDEX_W-1:0];
                r.word = class_words[i];
                r.hits = class_hits[i][COUNT_OUT_W-1:0];
                r.ovf  = 1'b0;
                r.fin  = (i + 1 == classes_used);
                expected_results.push_back(r);
            end
            classes_used = 0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_val,
                                        input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $error("field %s expected %0h actual %0h", name, exp_val, act_val);
        end
    endfunction

    // ------------------------------------------------------------------
    // sample driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            samples.valid        <= 1'b0;
            samples.sample_value <= '0;
            samples.end_of_set   <= 1'b0;
            burst_left           <= 0;
            gap_left             <= 0;
        end
        else
        begin
            // the model advances on the transfer, not on presentation
            if (samples.valid && samples.ready)
                classify_sample(samples.sample_value, samples.end_of_set);
            // only move on once the presented word is taken (or nothing is presented)
            if (!samples.valid || samples.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    samples.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    nxt = pending_samples.pop_front();
                    samples.valid        <= 1'b1;
                    samples.sample_value <= nxt.word;
                    samples.end_of_set   <= nxt.last;
                    if (burst_left <= 1)
                    begin
                        // new burst; a quarter of them follow with no gap at all
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                                   : $urandom_range(1, 10);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    samples.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = '1;
    int          pattern_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        class_result_t exp_r;
        logic [15:0]   pat;
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            ready_pattern <= '1;
            pattern_left  <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $error("result transfer with nothing expected: kind %0b index %0d",
                           results.result_kind, results.class_index);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("result_kind", WORD_W'(exp_r.kind),
                                WORD_W'(results.result_kind));
                    check_field("class_index", WORD_W'(exp_r.cls),
                                WORD_W'(results.class_index));
                    check_field("entry_value", exp_r.word, results.entry_value);
                    check_field("entry_count", WORD_W'(exp_r.hits),
                                WORD_W'(results.entry_count));
                    check_field("table_overflow", WORD_W'(exp_r.ovf),
                                WORD_W'(results.table_overflow));
                    check_field("final_result", WORD_W'(exp_r.fin),
                                WORD_W'(results.final_result));
                end
            end
            // rotating 16 bit ready pattern, reshuffled whenever pattern_left runs out
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pat = '1;                                   // no stalls
                    1: pat = 16'h0001 << $urandom_range(0, 15);    // long stalls
                    default: pat = 16'($urandom_range(0, 16'hffff)) | 16'h0001;
                endcase
                ready_pattern <= pat;
                pattern_left  <= $urandom_range(16, 80);
                results.ready <= pat[0];
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                pattern_left  <= pattern_left - 1;
                results.ready <= ready_pattern[1];
            end
        end
    end

    // ------------------------------------------------------------------
    // hang watchdog: no transfer on either side for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= HANG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
        sample_t s;
        s.word = word;
        s.last = last;
        // keep the queue short so long sets do not pile up in memory
        while (pending_samples.size() > 256)
            @(negedge clk);
        pending_samples.push_back(s);
    endtask

    // wait until every word is sent and every result is back, then let the block settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || samples.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [WORD_W-1:0] pool [64];
        int                sent;
        int                set_len;
        int                pool_len;

        samples.valid        = 1'b0;
        samples.sample_value = '0;
        samples.end_of_set   = 1'b0;
        results.ready        = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, a hit, then a dump of several entries
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word('1, 1'b1);
        // a set of one new word: dump of a single entry
        send_word(64'h7fff_ffff_ffff_ffff, 1'b1);
        // fill the table, then overflow, hit while full, overflow on the end of set
        for (int i = 0; i < MAX_CLASSES; i++)
            send_word(64'h0000_0001_0000_0000 << (i % 32) | WORD_W'(i), 1'b0);
        send_word(64'hdead_beef_0000_0000, 1'b0);
        send_word(64'h0000_0001_0000_0000, 1'b0);
        send_word(64'h0123_4567_89ab_cdef, 1'b1);
        wait_drained();

        // random sets drawn from small pools so words repeat; some pools overflow the table
        sent = 0;
        while (sent < 450)
        begin
            pool_len = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_CLASSES, 64)
                                                    : $urandom_range(1, 12);
            for (int i = 0; i < pool_len; i++)
            begin
                // neighbors one bit apart stress the exact compare
                if (i != 0 && $urandom_range(0, 3) == 0)
                    pool[i] = pool[i-1] ^ (64'h1 << $urandom_range(0, 63));
                else
                    pool[i] = rand_word();
            end
            set_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, pool_len + 30);
            for (int i = 0; i < set_len; i++)
                send_word(pool[$urandom_range(0, pool_len - 1)], (i == set_len - 1));
            sent += set_len;
        end
        wait_drained();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dvcm_pkg.sv
hw/rtl/dvcm_if.sv
hw/rtl/dvcm_cell.sv
hw/rtl/distinct_value_class_mapper.sv
tb/distinct_value_class_mapper_tb.sv
